/* sv/onewire_temp_read_sequencer_defines.svh */
// Assertion macros shared by the temperature read sequencer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ONEWIRE_TEMP_READ_SEQUENCER_DEFINES_SVH
`define ONEWIRE_TEMP_READ_SEQUENCER_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define OWTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("owts same-cycle check failed");

// Next-cycle implication, gated off during reset.
`define OWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("owts next-cycle check failed");

`endif

/* sv/owts_pkg.sv */
// Package for the 1-Wire temperature read sequencer: phase type,
// config and result structs, register indexes and command bytes. No dependencies.
package owts_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_REC,
        PH_PRES_HI,
        PH_PRES_LO,
        PH_WR_A,
        PH_WR_B,
        PH_RD_LOW,
        PH_RD_REL,
        PH_RD_WAIT
    } t_phase;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW   = 3'd0;
    localparam logic [2:0] CFG_RECOVERY    = 3'd1;
    localparam logic [2:0] CFG_SHORT_PULSE = 3'd2;
    localparam logic [2:0] CFG_SLOT        = 3'd3;
    localparam logic [2:0] CFG_READ_WAIT   = 3'd4;
    localparam logic [2:0] CFG_PRES_TMO    = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_RESET_LOW   = 16'd75;
    localparam logic [15:0] RST_RECOVERY    = 16'd2;
    localparam logic [7:0]  RST_SHORT_PULSE = 8'd1;
    localparam logic [15:0] RST_SLOT        = 16'd6;
    localparam logic [15:0] RST_READ_WAIT   = 16'd5;
    localparam logic [7:0]  RST_PRES_TMO    = 8'd20;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT      = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    // Byte counter milestones
    localparam logic [2:0] BYTE_SECOND_RESET = 3'd2;
    localparam logic [2:0] BYTE_READ_FIRST   = 3'd4;
    localparam logic [2:0] BYTE_READ_SECOND  = 3'd5;

    typedef struct packed {
        logic [15:0] reset_low;
        logic [15:0] recovery;
        logic [7:0]  short_pulse;
        logic [15:0] slot;
        logic [15:0] read_wait;
        logic [7:0]  pres_timeout;
    } t_cfg;

    typedef struct packed {
        logic               line_release;
        logic               busy;
        logic               done;
        logic               presence_error;
        logic signed [15:0] temperature;
    } t_result;

    function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SCRATCH;
        endcase
        return b;
    endfunction

endpackage

/* sv/onewire_temp_read_sequencer.sv */
// Top level of the 1-Wire temperature read sequencer: config registers,
// tick sequencer and result register. Depends on owts_pkg and the defines header.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    i_line_in, i_start_request
//  result   out        o_out_valid / i_out_stall  o_line_release, o_busy_res,
//                                                 o_done_res, o_presence_error,
//                                                 o_temperature
//  config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One tick per cycle while the input is not stalled: each transfer on the input
// advances the sequencer by one bus tick, and its result lands in the result register
// on the same edge, computed from the sequencer state through its next-state logic.
// Reset (synchronous, active low) returns to idle and restores register defaults.
// A stalled result holds in the register; the input stalls only while that
// register is full and the consumer stalls, so a transfer can happen every cycle.
`include "onewire_temp_read_sequencer_defines.svh"

module onewire_temp_read_sequencer
    import owts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_line_in,
    input  logic               i_start_request,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_line_release,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic               o_presence_error,
    output logic signed [15:0] o_temperature,
    // configuration port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg    cfg;
    t_result seq_result;
    t_result out_result;
    logic    in_xfer;
    logic    out_blocked;
    logic    seq_idle;

    // Take a transfer whenever the result register can hold its result
    assign o_in_stall = out_blocked;
    assign in_xfer    = i_in_valid && !out_blocked;

    owts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance the bus sequence by one tick per accepted item
    owts_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (in_xfer),
        .i_line_in       (i_line_in),
        .i_start_request (i_start_request),
        .i_cfg           (cfg),
        .o_result        (seq_result),
        .o_idle          (seq_idle)
    );

    // Hold the result until the consumer takes it
    owts_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_xfer),
        .i_result       (seq_result),
        .i_out_stall    (i_out_stall),
        .o_valid        (o_out_valid),
        .o_full_stalled (out_blocked),
        .o_result       (out_result)
    );

    assign o_line_release   = out_result.line_release;
    assign o_busy_res       = out_result.busy;
    assign o_done_res       = out_result.done;
    assign o_presence_error = out_result.presence_error;
    assign o_temperature    = out_result.temperature;

    // A full, stalled result register must block the input
    `OWTS_ASSERT_NOW(a_block_when_full, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_in_stall)
    // An idle tick without a start reports not busy and releases the line
    `OWTS_ASSERT_NEXT(a_idle_tick, i_clk, i_rst_n,
        in_xfer && seq_idle && !i_start_request,
        o_out_valid && !o_busy_res && o_line_release && !o_done_res)
    // A start tick pulls the line low with a cleared error flag
    `OWTS_ASSERT_NEXT(a_start_tick, i_clk, i_rst_n,
        in_xfer && seq_idle && i_start_request,
        o_out_valid && o_busy_res && !o_line_release && !o_presence_error)
    // The sequence returns to idle after the tick that reports done
    `OWTS_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n,
        in_xfer && seq_result.done, seq_idle && o_busy_res)

endmodule

/* sv/owts_cfg_regs.sv */
// Configuration register file of the 1-Wire temperature read sequencer.
// Depends on owts_pkg for register indexes, reset values and t_cfg.
module owts_cfg_regs
    import owts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW:   n_cfg.reset_low    = i_cfg_data;
                CFG_RECOVERY:    n_cfg.recovery     = i_cfg_data;
                CFG_SHORT_PULSE: n_cfg.short_pulse  = i_cfg_data[7:0];
                CFG_SLOT:        n_cfg.slot         = i_cfg_data;
                CFG_READ_WAIT:   n_cfg.read_wait    = i_cfg_data;
                CFG_PRES_TMO:    n_cfg.pres_timeout = i_cfg_data[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low    <= RST_RESET_LOW;
            r_cfg.recovery     <= RST_RECOVERY;
            r_cfg.short_pulse  <= RST_SHORT_PULSE;
            r_cfg.slot         <= RST_SLOT;
            r_cfg.read_wait    <= RST_READ_WAIT;
            r_cfg.pres_timeout <= RST_PRES_TMO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/owts_seq.sv */
// Tick sequencer of the 1-Wire temperature read: phase, counters, shift
// register and held reading. Depends on owts_pkg.
module owts_seq
    import owts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  logic    i_line_in,
    input  logic    i_start_request,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output logic    o_idle
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic [2:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_low, n_low;
    logic        r_err, n_err;
    logic [15:0] r_temp, n_temp;

    // Phase and counters as seen this tick, after a start is taken
    t_phase      e_phase;
    logic [15:0] e_tick;
    logic [2:0]  e_bit;
    logic [2:0]  e_byte;
    logic        e_err;
    logic        cur_bit;
    logic [15:0] tick_inc;
    logic [15:0] phase_len;
    logic        timed_end;
    logic [15:0] short_len;
    logic [15:0] tmo_len;
    logic        last_bit;
    logic        seq_done;

    always_comb begin
        e_phase = r_phase;
        e_tick  = r_tick;
        e_bit   = r_bit;
        e_byte  = r_byte;
        e_err   = r_err;
        if ((r_phase == PH_IDLE) && i_start_request) begin
            e_phase = PH_RST_LOW;
            e_tick  = '0;
            e_bit   = '0;
            e_byte  = '0;
            e_err   = 1'b0;
        end
    end

    // Length of the current timed phase and its end condition
    always_comb begin
        cur_bit   = r_shift[0];
        short_len = {8'd0, i_cfg.short_pulse};
        tmo_len   = {8'd0, i_cfg.pres_timeout};
        tick_inc  = e_tick + 16'd1;
        last_bit  = (e_bit == 3'd7);
        case (e_phase)
            PH_RST_LOW: phase_len = i_cfg.reset_low;
            PH_RST_REC: phase_len = i_cfg.recovery;
            PH_WR_A:    phase_len = cur_bit ? short_len : i_cfg.slot;
            PH_WR_B:    phase_len = cur_bit ? i_cfg.slot : short_len;
            PH_RD_LOW:  phase_len = short_len;
            PH_RD_REL:  phase_len = short_len;
            PH_RD_WAIT: phase_len = i_cfg.read_wait;
            default:    phase_len = '0;
        endcase
        timed_end = (tick_inc >= phase_len);
        seq_done  = (e_phase == PH_RD_WAIT) && timed_end && last_bit
                    && (e_byte != BYTE_READ_FIRST);
    end

    // Next state
    always_comb begin
        n_phase = e_phase;
        n_tick  = e_tick;
        n_bit   = e_bit;
        n_byte  = e_byte;
        n_err   = e_err;
        n_shift = r_shift;
        n_low   = r_low;
        n_temp  = r_temp;
        unique case (e_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_RST_LOW, PH_RST_REC, PH_WR_A, PH_RD_LOW: begin
                n_tick = timed_end ? 16'd0 : tick_inc;
                if (timed_end) begin
                    case (e_phase)
                        PH_RST_LOW: n_phase = PH_RST_REC;
                        PH_RST_REC: n_phase = PH_PRES_HI;
                        PH_WR_A:    n_phase = PH_WR_B;
                        default:    n_phase = PH_RD_REL;
                    endcase
                end
            end
            PH_PRES_HI: begin
                if (i_line_in && (e_tick < tmo_len)) begin
                    n_tick = tick_inc;
                end else if (e_tick >= tmo_len) begin
                    n_err   = 1'b1;
                    n_phase = PH_WR_A;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_shift = cmd_byte(e_byte[1:0]);
                end else begin
                    n_phase = PH_PRES_LO;
                    n_tick  = '0;
                end
            end
            PH_PRES_LO: begin
                if (!i_line_in && (e_tick < tmo_len)) begin
                    n_tick = tick_inc;
                end else begin
                    if (e_tick >= tmo_len) begin
                        n_err = 1'b1;
                    end
                    n_phase = PH_WR_A;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_shift = cmd_byte(e_byte[1:0]);
                end
            end
            PH_WR_B: begin
                n_tick = timed_end ? 16'd0 : tick_inc;
                if (timed_end) begin
                    n_shift = {1'b0, r_shift[7:1]};
                    n_bit   = e_bit + 3'd1;
                    n_phase = PH_WR_A;
                    if (last_bit) begin
                        n_byte = e_byte + 3'd1;
                        if (n_byte == BYTE_SECOND_RESET) begin
                            n_phase = PH_RST_LOW;
                        end else if (n_byte >= BYTE_READ_FIRST) begin
                            n_byte  = BYTE_READ_FIRST;
                            n_shift = '0;
                            n_phase = PH_RD_LOW;
                        end else begin
                            n_shift = cmd_byte(n_byte[1:0]);
                            n_bit   = '0;
                        end
                    end
                end
            end
            PH_RD_REL: begin
                n_tick = timed_end ? 16'd0 : tick_inc;
                if (timed_end) begin
                    n_shift = {i_line_in, r_shift[7:1]};
                    n_phase = PH_RD_WAIT;
                end
            end
            PH_RD_WAIT: begin
                n_tick = timed_end ? 16'd0 : tick_inc;
                if (timed_end) begin
                    n_bit   = e_bit + 3'd1;
                    n_phase = PH_RD_LOW;
                    if (last_bit) begin
                        if (e_byte == BYTE_READ_FIRST) begin
                            n_low   = r_shift;
                            n_byte  = BYTE_READ_SECOND;
                            n_shift = '0;
                        end else begin
                            n_temp  = {r_shift, r_low};
                            n_phase = PH_IDLE;
                            n_byte  = '0;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    // Result of this tick
    always_comb begin
        o_result.line_release   = !((e_phase == PH_RST_LOW) || (e_phase == PH_WR_A)
                                    || (e_phase == PH_RD_LOW));
        o_result.busy           = (e_phase != PH_IDLE);
        o_result.done           = seq_done;
        o_result.presence_error = n_err;
        o_result.temperature    = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_low   <= '0;
            r_err   <= 1'b0;
            r_temp  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_low   <= n_low;
            r_err   <= n_err;
            r_temp  <= n_temp;
        end
    end

    assign o_idle = (r_phase == PH_IDLE);

endmodule

/* sv/owts_out_reg.sv */
// Result register of the 1-Wire temperature read sequencer; holds one
// result while the consumer stalls. Depends on owts_pkg for t_result.
module owts_out_reg
    import owts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_valid,
    output logic    o_full_stalled,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign n_valid        = i_load || (r_valid && i_out_stall);
    assign o_full_stalled = r_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* tb/tb_onewire_temp_read_sequencer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for onewire_temp_read_sequencer: a tick-level predictor of the
// 1-Wire temperature read checks every result transfer. Depends on owts_pkg and the RTL.
module tb_onewire_temp_read_sequencer;
    import owts_pkg::*;

    // Tick-level scoreboard: follows the sequencer one bus tick per accepted input
    // transfer and keeps the results still owed by the block, oldest first.
    class bus_tick_scoreboard;
        t_cfg        regs;
        t_phase      phase;
        logic [15:0] tick_count;
        logic [2:0]  bit_index;
        logic [2:0]  byte_index;
        logic [7:0]  shift_byte;
        logic [7:0]  low_byte;
        logic        error_flag;
        logic [15:0] temperature_hold;
        logic [7:0]  cmd_seq [4];
        t_result     owed_results [$];
        int unsigned errors;

        function new();
            cmd_seq = '{CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM, CMD_READ_SCRATCH};
            regs = '{RST_RESET_LOW, RST_RECOVERY, RST_SHORT_PULSE, RST_SLOT,
                     RST_READ_WAIT, RST_PRES_TMO};
            phase = PH_IDLE;
            tick_count = '0;
            bit_index = '0;
            byte_index = '0;
            shift_byte = '0;
            low_byte = '0;
            error_flag = 1'b0;
            temperature_hold = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_RESET_LOW:   regs.reset_low = val;
                CFG_RECOVERY:    regs.recovery = val;
                CFG_SHORT_PULSE: regs.short_pulse = val[7:0];
                CFG_SLOT:        regs.slot = val;
                CFG_READ_WAIT:   regs.read_wait = val;
                CFG_PRES_TMO:    regs.pres_timeout = val[7:0];
                default: ;
            endcase
        endfunction

        // Count one tick of a timed phase; a length of zero behaves as one.
        function bit period_over(logic [15:0] len);
            tick_count = tick_count + 16'd1;
            if (tick_count >= len) begin
                tick_count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void load_command();
            phase = PH_WR_A;
            tick_count = '0;
            bit_index = '0;
            shift_byte = cmd_seq[byte_index[1:0]];
        endfunction

        // Advance one bus tick and queue the result it owes.
        function void note_tick(logic lvl, logic req);
            t_result r;
            logic    cur_bit;
            r.line_release = 1'b1;
            r.done = 1'b0;
            if (phase == PH_IDLE && req) begin
                phase = PH_RST_LOW;
                tick_count = '0;
                byte_index = '0;
                bit_index = '0;
                error_flag = 1'b0;
            end
            r.busy = (phase != PH_IDLE);
            cur_bit = shift_byte[0];
            case (phase)
                PH_RST_LOW: begin
                    r.line_release = 1'b0;
                    if (period_over(regs.reset_low)) phase = PH_RST_REC;
                end
                PH_RST_REC: begin
                    if (period_over(regs.recovery)) phase = PH_PRES_HI;
                end
                PH_PRES_HI: begin
                    if (lvl && tick_count < regs.pres_timeout) begin
                        tick_count = tick_count + 16'd1;
                    end else if (tick_count >= regs.pres_timeout) begin
                        error_flag = 1'b1;
                        load_command();
                    end else begin
                        phase = PH_PRES_LO;
                        tick_count = '0;
                    end
                end
                PH_PRES_LO: begin
                    if (!lvl && tick_count < regs.pres_timeout) begin
                        tick_count = tick_count + 16'd1;
                    end else begin
                        if (tick_count >= regs.pres_timeout) error_flag = 1'b1;
                        load_command();
                    end
                end
                PH_WR_A: begin
                    r.line_release = 1'b0;
                    if (period_over(cur_bit ? {8'd0, regs.short_pulse} : regs.slot))
                        phase = PH_WR_B;
                end
                PH_WR_B: begin
                    if (period_over(cur_bit ? regs.slot : {8'd0, regs.short_pulse})) begin
                        shift_byte = shift_byte >> 1;
                        bit_index = bit_index + 3'd1;
                        phase = PH_WR_A;
                        if (bit_index == 3'd0) begin
                            byte_index = byte_index + 3'd1;
                            if (byte_index == BYTE_SECOND_RESET) begin
                                phase = PH_RST_LOW;
                            end else if (byte_index >= BYTE_READ_FIRST) begin
                                byte_index = BYTE_READ_FIRST;
                                shift_byte = '0;
                                phase = PH_RD_LOW;
                            end else begin
                                load_command();
                            end
                        end
                    end
                end
                PH_RD_LOW: begin
                    r.line_release = 1'b0;
                    if (period_over({8'd0, regs.short_pulse})) phase = PH_RD_REL;
                end
                PH_RD_REL: begin
                    if (period_over({8'd0, regs.short_pulse})) begin
                        shift_byte = {lvl, shift_byte[7:1]};
                        phase = PH_RD_WAIT;
                    end
                end
                PH_RD_WAIT: begin
                    if (period_over(regs.read_wait)) begin
                        bit_index = bit_index + 3'd1;
                        phase = PH_RD_LOW;
                        if (bit_index == 3'd0) begin
                            if (byte_index == BYTE_READ_FIRST) begin
                                low_byte = shift_byte;
                                byte_index = BYTE_READ_SECOND;
                                shift_byte = '0;
                            end else begin
                                temperature_hold = {shift_byte, low_byte};
                                r.done = 1'b1;
                                phase = PH_IDLE;
                                byte_index = '0;
                            end
                        end
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    tick_count = '0;
                end
            endcase
            r.presence_error = error_flag;
            r.temperature = temperature_hold;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_tick(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                         $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("line_release", want.line_release, got.line_release);
            compare_field("busy_res", want.busy, got.busy);
            compare_field("done_res", want.done, got.done);
            compare_field("presence_error", want.presence_error, got.presence_error);
            compare_field("temperature", want.temperature, got.temperature);
        endfunction
    endclass

    // Every input is known from time zero.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_line_in = 1'b1;
    logic               i_start_request = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_line_release;
    logic               o_busy_res;
    logic               o_done_res;
    logic               o_presence_error;
    logic signed [15:0] o_temperature;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    bus_tick_scoreboard sb;

    // Bus-side plan of the simulated sensor for the sequence in flight.
    logic [15:0] planned_temp = '0;
    int unsigned pres_hi_len = 0;
    int unsigned pres_lo_len = 0;
    bit          noisy = 1'b0;
    int unsigned item_count = 0;

    onewire_temp_read_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_line_in       (i_line_in),
        .i_start_request (i_start_request),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_release  (o_line_release),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_presence_error(o_presence_error),
        .o_temperature   (o_temperature),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #400000;
        $display("onewire_temp_read_sequencer verification failed");
        $finish;
    end

    // Poll length for one presence phase: mostly inside the timeout, sometimes
    // right at or past it so the error path gets exercised.
    function automatic int unsigned pick_poll(int unsigned tmo);
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, tmo - 1);
        return $urandom_range(tmo, tmo + 1);
    endfunction

    // Readings aimed at the edges of the signed range and at negative values.
    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return {5'h1F, 11'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short timings so many full reads complete; now and then a mid or top value.
    function automatic logic [15:0] pick_len(logic [15:0] top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return top;
        if (r < 13) return 16'($urandom_range(5, 24));
        return 16'($urandom_range(1, 3));
    endfunction

    // Bus level the sensor would present on the next tick, given where the
    // sequencer stands right now. Noisy sequences ignore the protocol.
    function automatic logic choose_line();
        int unsigned tmo;
        tmo = sb.regs.pres_timeout;
        if (noisy) return 1'($urandom_range(0, 1));
        case (sb.phase)
            PH_RST_REC: begin
                pres_hi_len = pick_poll(tmo);
                pres_lo_len = pick_poll(tmo);
            end
            PH_PRES_HI: return sb.tick_count < pres_hi_len;
            PH_PRES_LO: return sb.tick_count >= pres_lo_len;
            PH_RD_REL:  return planned_temp[{sb.byte_index == BYTE_READ_SECOND, sb.bit_index}];
            default: ;
        endcase
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one tick and hold it until the transfer; then maybe drop valid at random before the next tick.
    task automatic send_tick(input logic lvl, input logic req);
        i_in_valid <= 1'b1;
        i_line_in <= lvl;
        i_start_request <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_tick(lvl, req);
        item_count++;
        // no idling at all over a long middle stretch
        if (item_count < 500 || item_count >= 800) begin
            while ($urandom_range(0, 99) < 7) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Drop valid, let every owed result drain, then write all six registers.
    task automatic load_regs(input t_cfg c);
        i_in_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        put_reg(CFG_RESET_LOW, c.reset_low);
        put_reg(CFG_RECOVERY, c.recovery);
        put_reg(CFG_SHORT_PULSE, {8'd0, c.short_pulse});
        put_reg(CFG_SLOT, c.slot);
        put_reg(CFG_READ_WAIT, c.read_wait);
        put_reg(CFG_PRES_TMO, {8'd0, c.pres_timeout});
        i_cfg_we <= 1'b0;
    endtask

    // Random ticks: start mostly when idle (that is when it counts), stray starts
    // while busy, and bus levels from the sensor plan.
    task automatic run_ticks(input int unsigned n);
        logic req;
        repeat (n) begin
            if (sb.phase == PH_IDLE) begin
                req = ($urandom_range(0, 99) < 60);
                if (req) begin
                    planned_temp = pick_temp();
                    noisy = ($urandom_range(0, 99) < 12);
                end
            end else begin
                req = ($urandom_range(0, 99) < 15);
            end
            send_tick(choose_line(), req);
        end
    endtask

    // Result side: check every result transfer, stall now and then, hold off
    // once for a long stretch so the block backs up into its input, and leave
    // a long window with no stalls.
    initial begin : result_sink
        int unsigned cyc;
        t_result     got;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{o_line_release, o_busy_res, o_done_res, o_presence_error,
                        o_temperature};
                sb.check_tick(got);
            end
            cyc++;
            if (cyc >= 300 && cyc < 348)
                i_out_stall <= 1'b1;
            else if (cyc >= 700 && cyc < 1100)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(0, 99) < 7);
        end
    end

    initial begin : stimulus
        t_cfg c;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset defaults: idle ticks at both bus levels, a start, then
        // starts while busy, which must be ignored.
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        repeat (13) send_tick(1'($urandom_range(0, 1)), 1'b0);

        // Every register at its top value; the read in flight stretches out and
        // is then cut short by the rewrite below.
        c = '{16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF};
        load_regs(c);
        run_ticks(150);

        // Every register at its bottom value.
        c = '{16'd1, 16'd1, 8'd1, 16'd1, 16'd1, 8'd1};
        load_regs(c);
        run_ticks(200);

        // Random settings; rewrites land mid-sequence as often as not.
        repeat (7) begin
            c.reset_low = pick_len(16'hFFFF);
            c.recovery = pick_len(16'hFFFF);
            c.short_pulse = 8'(pick_len(16'h00FF));
            c.slot = pick_len(16'hFFFF);
            c.read_wait = pick_len(16'hFFFF);
            c.pres_timeout = 8'(pick_len(16'h00FF));
            load_regs(c);
            run_ticks(130);
        end

        i_in_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        // catch any stray result after the last one owed
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_results.size() == 0)
            $display("onewire_temp_read_sequencer verification clean");
        else
            $display("onewire_temp_read_sequencer verification failed");
        $finish;
    end

endmodule
